### sv/ffic_pkg.sv
// ----------------------------------------------------------------------------
// ffic_pkg
// Types and constants shared by the float / fixed / int converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ffic_pkg;

    typedef enum logic [1:0] {
        OP_FLOAT_TO_FIXED = 2'd0,
        OP_FIXED_TO_FLOAT = 2'd1,
        OP_FIXED_TO_INT   = 2'd2,
        OP_INT_TO_FIXED   = 2'd3
    } t_op;

    typedef struct packed {
        logic [31:0] bits;
        logic        overflow;
    } t_result;

    localparam logic [31:0] POS_SAT   = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_SAT   = 32'h8000_0000;
    localparam int          EXP_BIAS  = 127;
    localparam int          MANT_BITS = 23;
    localparam logic [7:0]  EXP_SPECIAL = 8'hFF;

endpackage

`default_nettype wire

### sv/ffic_in_if.sv
// ----------------------------------------------------------------------------
// ffic_in_if
// Request channel: operation select and 32-bit operand.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] operand_bits;

    modport source (output valid, output operation, output operand_bits, input ready);
    modport sink   (input valid, input operation, input operand_bits, output ready);
endinterface

`default_nettype wire

### sv/ffic_out_if.sv
// ----------------------------------------------------------------------------
// ffic_out_if
// Result channel: 32-bit result and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    logic        overflow;

    modport source (output valid, output result_bits, output overflow, input ready);
    modport sink   (input valid, input result_bits, input overflow, output ready);
endinterface

`default_nettype wire

### sv/ffic_conv.sv
// ----------------------------------------------------------------------------
// ffic_conv
// Combinational conversion datapath for all four operations.
// ----------------------------------------------------------------------------
`default_nettype none

module ffic_conv #(
    parameter int FRACTION_BITS = 8
) (
    input  ffic_pkg::t_op     i_op,
    input  logic [31:0]       i_operand,
    output ffic_pkg::t_result o_result
);
    import ffic_pkg::*;

    // shift that places the mantissa lsb at the fixed-point lsb
    localparam int ALIGN     = FRACTION_BITS - EXP_BIAS - MANT_BITS;
    localparam int MAX_LSH   = 31 - MANT_BITS;
    localparam int MAX_RSH   = MANT_BITS + 1;
    localparam int FX_BIAS   = EXP_BIAS - FRACTION_BITS;

    // float to fixed
    logic              f_neg;
    logic [7:0]        f_exp;
    logic [23:0]       f_mant;
    logic signed [9:0] f_sh;
    logic [4:0]        f_rsh;
    logic [24:0]       f_rnd_vec;
    logic [32:0]       f_mag;
    logic [32:0]       f_limit;
    t_result           f2x;

    // fixed to float
    logic [31:0]       x_mag;
    logic [4:0]        x_lead;
    logic [31:0]       x_norm;
    logic [7:0]        x_exp;
    t_result           x2f;

    // fixed to int
    logic [31:0]       x_floor;
    t_result           x2i;

    // int to fixed
    logic [FRACTION_BITS:0] i_top;
    t_result                i2x;

    always_comb begin
        f_neg     = i_operand[31];
        f_exp     = i_operand[30:23];
        f_mant    = {1'b1, i_operand[22:0]};
        f_sh      = $signed({2'b00, f_exp}) + 10'(ALIGN);
        f_rsh     = 5'(-f_sh);
        f_rnd_vec = {f_mant, 1'b0} >> f_rsh;
        f_limit   = f_neg ? {1'b0, NEG_SAT} : {1'b0, POS_SAT};
        f_mag     = '0;
        if (f_sh >= 10'sd0) begin
            f_mag = {9'd0, f_mant} << f_sh[3:0];
        end else if (f_sh >= -10'(MAX_RSH)) begin
            // round half away from zero on the magnitude
            f_mag = {9'd0, f_rnd_vec[24:1]} + {32'd0, f_rnd_vec[0]};
        end
        f2x.overflow = 1'b0;
        f2x.bits     = f_neg ? (32'd0 - f_mag[31:0]) : f_mag[31:0];
        if (f_exp == 8'd0) begin
            f2x.bits = '0;
        end else if (f_exp == EXP_SPECIAL || f_sh > 10'(MAX_LSH) || f_mag > f_limit) begin
            f2x.bits     = f_neg ? NEG_SAT : POS_SAT;
            f2x.overflow = 1'b1;
        end
    end

    always_comb begin
        x_mag  = i_operand[31] ? (32'd0 - i_operand) : i_operand;
        x_lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (x_mag[i]) begin
                x_lead = 5'(i);
            end
        end
        x_norm       = x_mag << (5'd31 - x_lead);
        x_exp        = 8'(x_lead) + 8'(FX_BIAS);
        x2f.overflow = 1'b0;
        x2f.bits     = (i_operand == 32'd0) ? 32'd0 : {i_operand[31], x_exp, x_norm[30:8]};
    end

    always_comb begin
        x_floor      = 32'($signed(i_operand) >>> FRACTION_BITS);
        x2i.overflow = 1'b0;
        x2i.bits     = x_floor + {31'd0, i_operand[FRACTION_BITS-1]};
    end

    always_comb begin
        // fits when the bits shifted out and the new sign bit all equal the sign
        i_top        = i_operand[31:31-FRACTION_BITS];
        i2x.overflow = !((i_top == '0) || (i_top == '1));
        i2x.bits     = i2x.overflow ? (i_operand[31] ? NEG_SAT : POS_SAT)
                                    : (i_operand << FRACTION_BITS);
    end

    always_comb begin
        unique case (i_op)
            OP_FLOAT_TO_FIXED: o_result = f2x;
            OP_FIXED_TO_FLOAT: o_result = x2f;
            OP_FIXED_TO_INT:   o_result = x2i;
            OP_INT_TO_FIXED:   o_result = i2x;
            default:           o_result = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/fixed_float_int_converter.sv
// the request is registered in the input stage and the result in the output stage
// throughput: one request per cycle; both stages advance together when downstream is ready
// the conversion itself is one pass through ffic_conv between the two registers
// reset: synchronous active-low i_rst_n clears both stage valid flags; no other state
// ----------------------------------------------------------------------------
// fixed_float_int_converter
// Converts between single-precision float, 32-bit int and signed fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_float_int_converter #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ffic_in_if.sink           i_req,
    ffic_out_if.source        o_rsp
);
    import ffic_pkg::*;

    logic        r_in_valid;
    t_op         r_in_op;
    logic [31:0] r_in_bits;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        out_adv;
    logic        in_adv;

    assign out_adv     = !r_out_valid || o_rsp.ready;
    assign in_adv      = !r_in_valid || out_adv;
    assign i_req.ready = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_req.valid) begin
            r_in_op   <= t_op'(i_req.operation);
            r_in_bits <= i_req.operand_bits;
        end
    end

    ffic_conv #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_conv (
        .i_op      (r_in_op),
        .i_operand (r_in_bits),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_bits = r_out.bits;
    assign o_rsp.overflow    = r_out.overflow;

`ifndef SYNTHESIS
    // a result only appears after a request was held in the input stage
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result valid without a pending request");

    // back-pressure only when both stages are full and the result is stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_out_valid && !o_rsp.ready))
        else $error("request refused while a stage was free");

    // fixed to float and fixed to int never overflow
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_op == OP_FIXED_TO_FLOAT || r_in_op == OP_FIXED_TO_INT))
            |-> !n_out.overflow)
        else $error("overflow on a non-saturating operation");

    // an overflow always comes with a saturated value
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && n_out.overflow) |-> (n_out.bits == POS_SAT || n_out.bits == NEG_SAT))
        else $error("overflow without saturation");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the float / fixed / int converter against a bit-exact conversion
// predictor, with bursty requests, receiver stalls and a long output hold.
// ----------------------------------------------------------------------------

module tb;
    import ffic_pkg::*;

    localparam int     FRAC_BITS = 8;
    localparam longint FIX_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint FIX_MIN   = -64'sh0000_0000_8000_0000;

    typedef struct {
        t_op         op;
        logic [31:0] operand;
        t_result     res;
    } t_expected;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffic_in_if  req_if ();
    ffic_out_if rsp_if ();

    fixed_float_int_converter #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_expected pending_results[$];
    int        mismatch_count = 0;
    int        burst_left     = 0;
    int        gap_max        = 0;
    bit        stall_en       = 1'b0;
    int        hold_left      = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // conversion predictor
    // ------------------------------------------------------------------------
    function automatic t_result predict_conversion(t_op op, logic [31:0] v);
        t_result     r;
        logic [23:0] mant;
        logic [63:0] mag;
        logic [63:0] limit;
        logic [31:0] umag;
        logic [31:0] frac;
        logic [7:0]  bexp;
        int          sh;
        int          rs;
        int          p;
        longint      scaled;
        r.bits     = 32'd0;
        r.overflow = 1'b0;
        case (op)
            OP_FLOAT_TO_FIXED: begin
                mant  = {1'b1, v[22:0]};
                limit = v[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
                sh    = int'(v[30:23]) - EXP_BIAS - MANT_BITS + FRAC_BITS;
                mag   = 64'd0;
                if (v[30:23] == 8'd0) begin
                    r.bits = 32'd0;
                end else if (v[30:23] == EXP_SPECIAL || sh > 32) begin
                    r.bits     = v[31] ? NEG_SAT : POS_SAT;
                    r.overflow = 1'b1;
                end else begin
                    if (sh >= 0) begin
                        mag = 64'(mant) << sh;
                    end else begin
                        rs = -sh;
                        // round half away from zero on the magnitude
                        if (rs <= 24)
                            mag = 64'(mant >> rs) + 64'(mant[rs-1]);
                    end
                    if (mag > limit) begin
                        r.bits     = v[31] ? NEG_SAT : POS_SAT;
                        r.overflow = 1'b1;
                    end else begin
                        r.bits = v[31] ? 32'd0 - mag[31:0] : mag[31:0];
                    end
                end
            end
            OP_FIXED_TO_FLOAT: begin
                if (v != 32'd0) begin
                    umag = v[31] ? 32'd0 - v : v;
                    p    = 0;
                    for (int i = 0; i < 32; i++)
                        if (umag[i]) p = i;
                    frac = umag & ~(32'd1 << p);
                    if (p > MANT_BITS) frac = frac >> (p - MANT_BITS);
                    else frac = frac << (MANT_BITS - p);
                    bexp   = 8'(EXP_BIAS + p - FRAC_BITS);
                    r.bits = {v[31], bexp, frac[22:0]};
                end
            end
            OP_FIXED_TO_INT: begin
                r.bits = 32'($signed(v) >>> FRAC_BITS) + 32'(v[FRAC_BITS-1]);
            end
            default: begin
                scaled = longint'($signed(v)) * (longint'(1) << FRAC_BITS);
                if (scaled > FIX_MAX) begin
                    r.bits     = POS_SAT;
                    r.overflow = 1'b1;
                end else if (scaled < FIX_MIN) begin
                    r.bits     = NEG_SAT;
                    r.overflow = 1'b1;
                end else begin
                    r.bits = scaled[31:0];
                end
            end
        endcase
        return r;
    endfunction

    // operands weighted toward the interesting ranges of each conversion
    function automatic logic [31:0] rand_operand(t_op op);
        logic [7:0]  e;
        logic [31:0] v;
        v = $urandom;
        case (op)
            OP_FLOAT_TO_FIXED: begin
                case ($urandom_range(0, 9))
                    0: e = 8'(0);
                    1: e = EXP_SPECIAL;
                    2, 3: e = 8'($urandom_range(0, 255));
                    default: e = 8'($urandom_range(112, 152));
                endcase
                v[30:23] = e;
            end
            OP_INT_TO_FIXED: begin
                if ($urandom_range(0, 2) != 0)
                    v = 32'($signed(v) >>> $urandom_range(8, 31));
            end
            default: begin
                if ($urandom_range(0, 2) == 0)
                    v = 32'($signed(v) >>> $urandom_range(1, 31));
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string field, t_expected exp_item, logic [31:0] got,
                                   logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t mismatch %s: op %s operand %h got %h want %h", $realtime, field,
                     exp_item.op.name(), exp_item.operand, got, want);
    endtask

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_req(t_op op, logic [31:0] operand);
        t_expected exp_item;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.operand_bits <= operand;
        do @(posedge i_clk); while (!req_if.ready);
        exp_item.op      = op;
        exp_item.operand = operand;
        exp_item.res     = predict_conversion(op, operand);
        pending_results.push_back(exp_item);
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: own rotating stall pattern, plus a long hold on request
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] stall_pattern;
        int          stall_phase;
        stall_pattern = 32'hFFFF_FFFF;
        stall_phase   = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_phase == 0) stall_pattern = $urandom | 32'h1;
            stall_phase = (stall_phase + 1) % 32;
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= !stall_en || stall_pattern[stall_phase];
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_expected exp_item;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                exp_item.op      = OP_FLOAT_TO_FIXED;
                exp_item.operand = 32'd0;
                report_mismatch("unexpected result", exp_item, rsp_if.result_bits, 32'd0);
            end else begin
                exp_item = pending_results.pop_front();
                if (rsp_if.result_bits !== exp_item.res.bits)
                    report_mismatch("result_bits", exp_item, rsp_if.result_bits,
                                    exp_item.res.bits);
                if (rsp_if.overflow !== exp_item.res.overflow)
                    report_mismatch("overflow", exp_item, 32'(rsp_if.overflow),
                                    32'(exp_item.res.overflow));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        gap_max  = 2;
        stall_en = 1'b1;
        // zeros, subnormal, infinities and NaNs
        send_req(OP_FLOAT_TO_FIXED, 32'h0000_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'h8000_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'h0040_0001);
        send_req(OP_FLOAT_TO_FIXED, 32'h7F80_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'hFF80_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'h7FC0_0001);
        send_req(OP_FLOAT_TO_FIXED, 32'hFFC0_0000);
        // half an lsb rounds away from zero, a quarter goes to zero
        send_req(OP_FLOAT_TO_FIXED, 32'h3B00_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'hBA80_0000);
        // 2^23: positive saturates, negative just fits
        send_req(OP_FLOAT_TO_FIXED, 32'h4B00_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'hCB00_0000);
        send_req(OP_FLOAT_TO_FIXED, 32'h7F7F_FFFF);
        send_req(OP_FIXED_TO_FLOAT, 32'h0000_0000);
        send_req(OP_FIXED_TO_FLOAT, 32'h8000_0000);
        send_req(OP_FIXED_TO_FLOAT, 32'h7FFF_FFFF);
        send_req(OP_FIXED_TO_FLOAT, 32'h0000_0001);
        send_req(OP_FIXED_TO_INT, 32'h0000_0080);
        send_req(OP_FIXED_TO_INT, 32'hFFFF_FF7F);
        send_req(OP_FIXED_TO_INT, 32'h8000_0000);
        // int to fixed saturation boundaries
        send_req(OP_INT_TO_FIXED, 32'h007F_FFFF);
        send_req(OP_INT_TO_FIXED, 32'h0080_0000);
        send_req(OP_INT_TO_FIXED, 32'hFF80_0000);
        send_req(OP_INT_TO_FIXED, 32'hFF7F_FFFF);
    endtask

    task automatic test_random(int count);
        t_op op;
        gap_max  = 4;
        stall_en = 1'b1;
        for (int i = 0; i < count; i++) begin
            op = t_op'($urandom_range(0, 3));
            send_req(op, rand_operand(op));
        end
    endtask

    task automatic test_no_idle(int count);
        t_op op;
        gap_max  = 0;
        stall_en = 1'b0;
        for (int i = 0; i < count; i++) begin
            op = t_op'($urandom_range(0, 3));
            send_req(op, rand_operand(op));
        end
    endtask

    // output held off long enough that the block fills and stalls its input
    task automatic test_output_hold(int count);
        t_op op;
        gap_max   = 0;
        stall_en  = 1'b0;
        hold_left = 80;
        for (int i = 0; i < count; i++) begin
            op = t_op'($urandom_range(0, 3));
            send_req(op, rand_operand(op));
        end
    endtask

    task automatic test_drain_pause(int rounds, int count);
        t_op op;
        gap_max  = 3;
        stall_en = 1'b1;
        for (int k = 0; k < rounds; k++) begin
            for (int i = 0; i < count; i++) begin
                op = t_op'($urandom_range(0, 3));
                send_req(op, rand_operand(op));
            end
            wait_drain();
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.operation    <= OP_FLOAT_TO_FIXED;
        req_if.operand_bits <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        test_no_idle(40);
        test_output_hold(40);
        test_drain_pause(3, 20);

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### fixed_float_int_converter.f
sv/ffic_pkg.sv
sv/ffic_in_if.sv
sv/ffic_out_if.sv
sv/ffic_conv.sv
sv/fixed_float_int_converter.sv
tb/tb.sv
